>>> src/ptt_pkg.sv
// shared types and constants for the periodic timer table
// no dependencies; used by every module of the block
package ptt_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int HANDLE_W  = 16;
    localparam int OWNER_W   = 16;
    localparam int PERIOD_W  = 31;
    localparam int WBYTES_W  = 8;
    localparam int SLOTID_W  = 5;
    localparam int MAX_FIRES = 32;
    localparam int NFIRE_W   = $clog2(MAX_FIRES + 1);

    localparam logic [WBYTES_W-1:0] GOOD_WRITE = WBYTES_W'(4);
    localparam logic [NFIRE_W-1:0]  FIRE_CAP   = NFIRE_W'(MAX_FIRES);

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_SET   = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_SIZE  = 2'd3
    } t_status;

    typedef enum logic {
        RES_ACK  = 1'b0,
        RES_FIRE = 1'b1
    } t_res_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
    } t_slot;

endpackage

>>> src/periodic_timer_table_core.sv
// top level of the periodic timer table: slot ring, head logic and sequencer
// depends on ptt_pkg and ptt_cell
//
//  channel   signals                                              handshake
//  request   i_kind i_handle i_owner i_period i_write_bytes       start / busy
//  result    o_result_kind o_status o_fire_owner o_fire_slot      o_strobe
//            o_last
//
// an item is accepted, then a sweep rotates the ring of slot cells once past
// the head logic (one slot a cycle), then the item finishes.
// each fire of a tick is held until the next firing slot is seen, so fires
// show up during the rotation, at most one a cycle; the last fire and every
// acknowledgement show up in the cycle after finish, when busy is already low.
// synchronous active-low reset clears every slot and the sequencer.
// results are shown for one cycle with o_strobe; the receiver cannot stall.
module periodic_timer_table_core #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_kind,
    input  logic [ptt_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [ptt_pkg::OWNER_W-1:0]    i_owner,
    input  logic [ptt_pkg::PERIOD_W-1:0]   i_period,
    input  logic [ptt_pkg::WBYTES_W-1:0]   i_write_bytes,
    output logic                           o_strobe,
    output logic                           o_result_kind,
    output logic [1:0]                     o_status,
    output logic [ptt_pkg::OWNER_W-1:0]    o_fire_owner,
    output logic [ptt_pkg::SLOTID_W-1:0]   o_fire_slot,
    output logic                           o_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(SLOTS - 1);

    ptt_pkg::t_slot slots [SLOTS];
    ptt_pkg::t_slot head;
    ptt_pkg::t_slot proc_slot;
    logic           shift;

    ptt_pkg::t_state r_state, n_state;
    ptt_pkg::t_kind  r_kind, n_kind;
    logic [ptt_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [ptt_pkg::OWNER_W-1:0]  r_owner, n_owner;
    logic [ptt_pkg::PERIOD_W-1:0] r_period, n_period;
    logic                         r_wb_ok, n_wb_ok;
    logic [SW-1:0]                r_step, n_step;
    logic                         r_found, n_found;
    logic [SW-1:0]                r_hit_slot, n_hit_slot;
    logic                         r_pend_valid, n_pend_valid;
    logic [ptt_pkg::OWNER_W-1:0]  r_pend_owner, n_pend_owner;
    logic [ptt_pkg::NFIRE_W-1:0]  r_nfire, n_nfire;

    logic                         r_strobe, n_strobe;
    logic                         r_res_kind, n_res_kind;
    logic [1:0]                   r_status, n_status;
    logic [ptt_pkg::OWNER_W-1:0]  r_fire_owner, n_fire_owner;
    logic [ptt_pkg::SLOTID_W-1:0] r_fire_slot, n_fire_slot;
    logic                         r_last, n_last;

    logic head_match, head_free, head_active;

    // ring of slot cells: the head slot passes through the update logic
    // and re-enters at the tail
    genvar k;
    generate
        for (k = 0; k < SLOTS; k++) begin : g_cell
            if (k == SLOTS - 1) begin : g_tail
                ptt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_slot  (proc_slot),
                    .o_slot  (slots[k])
                );
            end else begin : g_body
                ptt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_slot  (slots[k + 1]),
                    .o_slot  (slots[k])
                );
            end
        end
    endgenerate

    assign head  = slots[0];
    assign shift = (r_state == ptt_pkg::ST_SWEEP);
    assign busy  = (r_state != ptt_pkg::ST_IDLE);

    // head slot comparisons
    assign head_match  = (head.handle == r_handle) && (head.owner == r_owner);
    assign head_free   = (head.handle == '0) && (head.owner == '0);
    assign head_active = (head.handle != '0) && (head.owner != '0)
                         && (head.period != '0);

    // sequencer, head update and result selection
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_handle     = r_handle;
        n_owner      = r_owner;
        n_period     = r_period;
        n_wb_ok      = r_wb_ok;
        n_step       = r_step;
        n_found      = r_found;
        n_hit_slot   = r_hit_slot;
        n_pend_valid = r_pend_valid;
        n_pend_owner = r_pend_owner;
        n_nfire      = r_nfire;
        proc_slot    = head;
        n_strobe     = 1'b0;
        n_res_kind   = r_res_kind;
        n_status     = r_status;
        n_fire_owner = r_fire_owner;
        n_fire_slot  = r_fire_slot;
        n_last       = r_last;

        case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (start) begin
                    n_kind       = ptt_pkg::t_kind'(i_kind);
                    n_handle     = i_handle;
                    n_owner      = i_owner;
                    n_period     = i_period;
                    n_wb_ok      = (i_write_bytes == ptt_pkg::GOOD_WRITE);
                    n_step       = '0;
                    n_found      = 1'b0;
                    n_pend_valid = 1'b0;
                    n_nfire      = '0;
                    n_state      = ptt_pkg::ST_SWEEP;
                end
            end

            ptt_pkg::ST_SWEEP: begin
                n_step = SW'(r_step + 1'b1);
                if (r_step == LAST_STEP) begin
                    n_state = ptt_pkg::ST_FINISH;
                end
                case (r_kind)
                    ptt_pkg::KIND_OPEN: begin
                        if (!r_found && head_free) begin
                            proc_slot.handle = r_handle;
                            proc_slot.owner  = r_owner;
                            proc_slot.period = '0;
                            proc_slot.count  = '0;
                            n_found          = 1'b1;
                            n_hit_slot       = r_step;
                        end
                    end
                    ptt_pkg::KIND_CLOSE: begin
                        if (!r_found && head_match) begin
                            proc_slot  = '0;
                            n_found    = 1'b1;
                            n_hit_slot = r_step;
                        end
                    end
                    ptt_pkg::KIND_SET: begin
                        if (r_wb_ok && !r_found && head_match) begin
                            proc_slot.period = r_period;
                            proc_slot.count  = r_period;
                            n_found          = 1'b1;
                            n_hit_slot       = r_step;
                        end
                    end
                    ptt_pkg::KIND_TICK: begin
                        if (head_active) begin
                            if (head.count <= ptt_pkg::PERIOD_W'(1)) begin
                                proc_slot.count = head.period;
                                if (r_nfire < ptt_pkg::FIRE_CAP) begin
                                    n_nfire = ptt_pkg::NFIRE_W'(r_nfire + 1'b1);
                                    // a newer fire proves the held one is not last
                                    if (r_pend_valid) begin
                                        n_strobe     = 1'b1;
                                        n_res_kind   = ptt_pkg::RES_FIRE;
                                        n_status     = ptt_pkg::STAT_OK;
                                        n_fire_owner = r_pend_owner;
                                        n_fire_slot  = ptt_pkg::SLOTID_W'(r_hit_slot);
                                        n_last       = 1'b0;
                                    end
                                    n_pend_valid = 1'b1;
                                    n_pend_owner = head.owner;
                                    n_hit_slot   = r_step;
                                end
                            end else begin
                                proc_slot.count = head.count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        proc_slot = head;
                    end
                endcase
            end

            ptt_pkg::ST_FINISH: begin
                n_state = ptt_pkg::ST_IDLE;
                if (r_kind == ptt_pkg::KIND_TICK) begin
                    if (r_pend_valid) begin
                        n_strobe     = 1'b1;
                        n_res_kind   = ptt_pkg::RES_FIRE;
                        n_status     = ptt_pkg::STAT_OK;
                        n_fire_owner = r_pend_owner;
                        n_fire_slot  = ptt_pkg::SLOTID_W'(r_hit_slot);
                        n_last       = 1'b1;
                    end
                end else begin
                    n_strobe     = 1'b1;
                    n_res_kind   = ptt_pkg::RES_ACK;
                    n_fire_owner = '0;
                    n_last       = 1'b1;
                    if (r_kind == ptt_pkg::KIND_SET && !r_wb_ok) begin
                        n_status    = ptt_pkg::STAT_BAD_SIZE;
                        n_fire_slot = '0;
                    end else if (r_found) begin
                        n_status    = ptt_pkg::STAT_OK;
                        n_fire_slot = ptt_pkg::SLOTID_W'(r_hit_slot);
                    end else if (r_kind == ptt_pkg::KIND_OPEN) begin
                        n_status    = ptt_pkg::STAT_FULL;
                        n_fire_slot = '0;
                    end else begin
                        n_status    = ptt_pkg::STAT_NOT_FOUND;
                        n_fire_slot = '0;
                    end
                end
            end

            default: begin
                n_state = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptt_pkg::ST_IDLE;
            r_step       <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_nfire      <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_found      <= n_found;
            r_pend_valid <= n_pend_valid;
            r_nfire      <= n_nfire;
            r_strobe     <= n_strobe;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_handle     <= n_handle;
        r_owner      <= n_owner;
        r_period     <= n_period;
        r_wb_ok      <= n_wb_ok;
        r_hit_slot   <= n_hit_slot;
        r_pend_owner <= n_pend_owner;
        r_res_kind   <= n_res_kind;
        r_status     <= n_status;
        r_fire_owner <= n_fire_owner;
        r_fire_slot  <= n_fire_slot;
        r_last       <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_res_kind;
    assign o_status      = r_status;
    assign o_fire_owner  = r_fire_owner;
    assign o_fire_slot   = r_fire_slot;
    assign o_last        = r_last;

endmodule

>>> src/ptt_cell.sv
// one timer slot of the rotating slot ring
// depends on ptt_pkg for the slot record type
module ptt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  ptt_pkg::t_slot i_slot,
    output ptt_pkg::t_slot o_slot
);

    ptt_pkg::t_slot r_slot;

    // take the neighbor's slot on every sweep cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

>>> src/ptt_checker.sv
// port-level checks for the periodic timer table, bound to the top level
// depends on ptt_pkg and periodic_timer_table_core
module ptt_port_checks (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic                         o_result_kind,
    input logic [1:0]                   o_status,
    input logic [ptt_pkg::OWNER_W-1:0]  o_fire_owner,
    input logic [ptt_pkg::SLOTID_W-1:0] o_fire_slot,
    input logic                         o_last
);

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // results only come out of work in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a transaction in progress");

    // fire events always carry ok status
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == ptt_pkg::RES_FIRE)
            |-> (o_status == ptt_pkg::STAT_OK))
        else $error("fire event with error status");

    // an acknowledgement is the single and final result of its transaction
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == ptt_pkg::RES_ACK)
            |-> (o_last && o_fire_owner == '0))
        else $error("acknowledgement not marked last or carries an owner");

    // error acknowledgements name no slot, and the transaction then ends
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == ptt_pkg::RES_ACK
            && o_status != ptt_pkg::STAT_OK) |-> (o_fire_slot == '0) ##1 !o_strobe)
        else $error("error acknowledgement with a slot index");

endmodule

bind periodic_timer_table_core ptt_port_checks u_ptt_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_result_kind (o_result_kind),
    .o_status      (o_status),
    .o_fire_owner  (o_fire_owner),
    .o_fire_slot   (o_fire_slot),
    .o_last        (o_last)
);

>>> test/ptt_checker.sv
`timescale 1ns / 1ps
// checker for the periodic timer table: follows accepted requests, predicts
// acknowledgements and fire events, compares every strobed result; uses ptt_pkg
module ptt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [1:0]                   i_kind,
    input  logic [ptt_pkg::HANDLE_W-1:0] i_handle,
    input  logic [ptt_pkg::OWNER_W-1:0]  i_owner,
    input  logic [ptt_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptt_pkg::WBYTES_W-1:0] i_write_bytes,
    input  logic                         i_strobe,
    input  logic                         i_result_kind,
    input  logic [1:0]                   i_status,
    input  logic [ptt_pkg::OWNER_W-1:0]  i_fire_owner,
    input  logic [ptt_pkg::SLOTID_W-1:0] i_fire_slot,
    input  logic                         i_last,
    output int                           o_fail_count,
    output int                           o_outstanding,
    output int                           o_fires_seen
);
    import ptt_pkg::*;

    typedef struct packed {
        t_res_kind           kind;
        t_status             status;
        logic [OWNER_W-1:0]  owner;
        logic [SLOTID_W-1:0] slot;
        logic                last;
    } t_outcome;

    // shadow copy of the slot table
    logic [HANDLE_W-1:0] timer_handle [SLOTS_DEF];
    logic [OWNER_W-1:0]  timer_owner  [SLOTS_DEF];
    logic [PERIOD_W-1:0] timer_period [SLOTS_DEF];
    logic [PERIOD_W-1:0] timer_count  [SLOTS_DEF];

    t_outcome pending_q[$];
    int       fails;
    int       fires;

    // first slot holding the pair, -1 when there is none
    function automatic int lookup_pair(input logic [HANDLE_W-1:0] h,
                                       input logic [OWNER_W-1:0] o);
        for (int i = 0; i < SLOTS_DEF; i++)
            if (timer_handle[i] == h && timer_owner[i] == o) return i;
        return -1;
    endfunction

    function automatic t_outcome make_ack(input t_status st, input int idx);
        make_ack = '{kind: RES_ACK, status: st, owner: '0,
                     slot: SLOTID_W'(idx), last: 1'b1};
    endfunction

    function automatic void clear_slot(input int idx);
        timer_handle[idx] = '0;
        timer_owner[idx]  = '0;
        timer_period[idx] = '0;
        timer_count[idx]  = '0;
    endfunction

    // update the shadow table for one transaction and queue its results
    task automatic apply_request(input t_kind k, input logic [HANDLE_W-1:0] h,
                                 input logic [OWNER_W-1:0] o,
                                 input logic [PERIOD_W-1:0] p,
                                 input logic [WBYTES_W-1:0] wb);
        int       idx;
        t_outcome held;
        bit       have;
        have = 1'b0;
        held = '0;
        case (k)
            KIND_OPEN: begin
                idx = lookup_pair('0, '0);
                if (idx < 0) begin
                    pending_q.push_back(make_ack(STAT_FULL, 0));
                end else begin
                    clear_slot(idx);
                    timer_handle[idx] = h;
                    timer_owner[idx]  = o;
                    pending_q.push_back(make_ack(STAT_OK, idx));
                end
            end
            KIND_CLOSE: begin
                idx = lookup_pair(h, o);
                if (idx < 0) begin
                    pending_q.push_back(make_ack(STAT_NOT_FOUND, 0));
                end else begin
                    clear_slot(idx);
                    pending_q.push_back(make_ack(STAT_OK, idx));
                end
            end
            KIND_SET: begin
                // a bad size wins over the lookup result
                idx = lookup_pair(h, o);
                if (wb != GOOD_WRITE) begin
                    pending_q.push_back(make_ack(STAT_BAD_SIZE, 0));
                end else if (idx < 0) begin
                    pending_q.push_back(make_ack(STAT_NOT_FOUND, 0));
                end else begin
                    timer_period[idx] = p;
                    timer_count[idx]  = p;
                    pending_q.push_back(make_ack(STAT_OK, idx));
                end
            end
            default: begin
                // tick: active slots count down in slot order, expired ones
                // reload and fire; the final fire carries last
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (timer_handle[i] == '0 || timer_owner[i] == '0 ||
                        timer_period[i] == '0) continue;
                    if (timer_count[i] <= PERIOD_W'(1)) begin
                        timer_count[i] = timer_period[i];
                        if (have) pending_q.push_back(held);
                        held = '{kind: RES_FIRE, status: STAT_OK, owner: timer_owner[i],
                                 slot: SLOTID_W'(i), last: 1'b0};
                        have = 1'b1;
                    end else begin
                        timer_count[i] = timer_count[i] - PERIOD_W'(1);
                    end
                end
                if (have) begin
                    held.last = 1'b1;
                    pending_q.push_back(held);
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_outcome want;
        if (pending_q.size() == 0) begin
            $error("unexpected result: kind %0d status %0d owner %0d slot %0d last %0d",
                   i_result_kind, i_status, i_fire_owner, i_fire_slot, i_last);
            fails++;
            return;
        end
        want = pending_q.pop_front();
        compare_field("result_kind", 32'(want.kind), 32'(i_result_kind));
        compare_field("status", 32'(want.status), 32'(i_status));
        compare_field("fire_owner", 32'(want.owner), 32'(i_fire_owner));
        compare_field("fire_slot", 32'(want.slot), 32'(i_fire_slot));
        compare_field("last", 32'(want.last), 32'(i_last));
        if (want.kind == RES_FIRE) fires++;
    endtask

    // results of earlier transactions are checked before a new one is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS_DEF; i++) clear_slot(i);
            pending_q.delete();
            fails = 0;
            fires = 0;
            o_fail_count  <= 0;
            o_outstanding <= 0;
            o_fires_seen  <= 0;
        end else begin
            if (i_strobe) check_result();
            if (i_start && !i_busy)
                apply_request(t_kind'(i_kind), i_handle, i_owner, i_period, i_write_bytes);
            o_fail_count  <= fails;
            o_outstanding <= pending_q.size();
            o_fires_seen  <= fires;
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench top for periodic_timer_table_core: clock, reset, request stimulus
// and verdict; depends on ptt_pkg, periodic_timer_table_core and ptt_checker
module tb_top;
    import ptt_pkg::*;

    typedef struct packed {
        logic [HANDLE_W-1:0] h;
        logic [OWNER_W-1:0]  o;
    } t_pair;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_kind               i_kind;
    logic [HANDLE_W-1:0] i_handle;
    logic [OWNER_W-1:0]  i_owner;
    logic [PERIOD_W-1:0] i_period;
    logic [WBYTES_W-1:0] i_write_bytes;
    logic                o_strobe;
    logic                o_result_kind;
    logic [1:0]          o_status;
    logic [OWNER_W-1:0]  o_fire_owner;
    logic [SLOTID_W-1:0] o_fire_slot;
    logic                o_last;

    int    fail_count;
    int    outstanding;
    int    fires_seen;
    int    issued [4];
    t_pair pair_pool[$];

    periodic_timer_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_handle      (i_handle),
        .i_owner       (i_owner),
        .i_period      (i_period),
        .i_write_bytes (i_write_bytes),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_fire_owner  (o_fire_owner),
        .o_fire_slot   (o_fire_slot),
        .o_last        (o_last)
    );

    ptt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_handle      (i_handle),
        .i_owner       (i_owner),
        .i_period      (i_period),
        .i_write_bytes (i_write_bytes),
        .i_strobe      (o_strobe),
        .i_result_kind (o_result_kind),
        .i_status      (o_status),
        .i_fire_owner  (o_fire_owner),
        .i_fire_slot   (o_fire_slot),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_fires_seen  (fires_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // ids: small values to provoke collisions, zero and all ones, full range
    function automatic logic [15:0] rand_id();
        case ($urandom_range(0, 5))
            0, 1:    rand_id = 16'($urandom_range(1, 6));
            2:       rand_id = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: rand_id = 16'($urandom);
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      rand_period = PERIOD_W'($urandom_range(1, 4));
        else if (r < 75) rand_period = PERIOD_W'($urandom_range(5, 20));
        else if (r < 85) rand_period = '0;
        else             rand_period = PERIOD_W'($urandom);
    endfunction

    function automatic logic [WBYTES_W-1:0] rand_bytes();
        if ($urandom_range(0, 99) < 85) rand_bytes = GOOD_WRITE;
        else                            rand_bytes = WBYTES_W'($urandom_range(0, 255));
    endfunction

    // mostly a pair that was opened earlier, sometimes an arbitrary one
    task automatic pick_pair(output logic [15:0] h, output logic [15:0] o);
        t_pair p;
        if (pair_pool.size() != 0 && $urandom_range(0, 99) < 80) begin
            p = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
            h = p.h;
            o = p.o;
        end else begin
            h = rand_id();
            o = rand_id();
        end
    endtask

    // drive one request and hold it until the block takes it
    task automatic issue(input t_kind k, input logic [15:0] h, input logic [15:0] o,
                         input logic [PERIOD_W-1:0] p, input logic [WBYTES_W-1:0] wb);
        start         <= 1'b1;
        i_kind        <= k;
        i_handle      <= h;
        i_owner       <= o;
        i_period      <= p;
        i_write_bytes <= wb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued[int'(k)]++;
        if (k == KIND_OPEN) begin
            pair_pool.push_back('{h: h, o: o});
            if (pair_pool.size() > 48) void'(pair_pool.pop_front());
        end
    endtask

    // random gap between transactions, long enough to land in any phase
    task automatic pause(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] h;
        logic [15:0] o;
        int          r;
        t_pair       p;

        start         <= 1'b0;
        i_kind        <= KIND_OPEN;
        i_handle      <= '0;
        i_owner       <= '0;
        i_period      <= '0;
        i_write_bytes <= '0;
        i_rst_n       <= 1'b0;
        foreach (issued[i]) issued[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request kind, bad size and not found statuses
        issue(KIND_TICK,  16'h0000, 16'h0000, '0, '0);           // empty table, silent
        issue(KIND_OPEN,  16'h0001, 16'h0001, '0, '0);
        issue(KIND_OPEN,  16'hFFFF, 16'hFFFF, '1, '1);
        issue(KIND_OPEN,  16'h0000, 16'h0000, '0, '0);           // slot still looks free
        issue(KIND_OPEN,  16'h0005, 16'h0000, '0, '0);           // reuses that slot
        issue(KIND_SET,   16'h0001, 16'h0001, PERIOD_W'(1), GOOD_WRITE);
        issue(KIND_SET,   16'hFFFF, 16'hFFFF, '1, GOOD_WRITE);
        issue(KIND_SET,   16'h0001, 16'h0001, PERIOD_W'(3), 8'd0);   // bad size
        issue(KIND_SET,   16'h0001, 16'h0001, PERIOD_W'(3), 8'd255);
        issue(KIND_SET,   16'h0002, 16'h0002, PERIOD_W'(3), 8'd5);
        issue(KIND_SET,   16'h0002, 16'h0002, PERIOD_W'(3), GOOD_WRITE); // not found
        issue(KIND_SET,   16'h0005, 16'h0000, PERIOD_W'(1), GOOD_WRITE); // owner zero
        issue(KIND_TICK,  '1, '1, '1, '1);
        issue(KIND_SET,   16'h0001, 16'h0001, PERIOD_W'(2), GOOD_WRITE);
        issue(KIND_TICK,  '0, '0, '0, '0);
        issue(KIND_TICK,  '0, '0, '0, '0);
        issue(KIND_SET,   16'h0001, 16'h0001, '0, GOOD_WRITE);       // disable
        issue(KIND_TICK,  '0, '0, '0, '0);
        issue(KIND_CLOSE, 16'h0003, 16'h0003, '0, '0);               // not found
        issue(KIND_CLOSE, 16'h0001, 16'h0001, '0, '0);
        issue(KIND_CLOSE, 16'hFFFF, 16'hFFFF, '0, '0);
        issue(KIND_CLOSE, 16'h0005, 16'h0000, '0, '0);
        issue(KIND_CLOSE, 16'h0000, 16'h0000, '0, '0);               // matches a free slot
        pair_pool.delete();

        // fill the table past full, arm every slot with period one, all fire
        for (int n = 0; n < SLOTS_DEF + 4; n++) begin
            issue(KIND_OPEN, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  rand_period(), rand_bytes());
            pause(1'b0);
        end
        foreach (pair_pool[i]) begin
            issue(KIND_SET, pair_pool[i].h, pair_pool[i].o, PERIOD_W'(1), GOOD_WRITE);
            pause(1'b0);
        end
        repeat (2) issue(KIND_TICK, rand_id(), rand_id(), rand_period(), rand_bytes());

        // random mix, with one long stretch of back-to-back transactions
        for (int n = 0; n < 70; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                issue(KIND_OPEN, rand_id(), rand_id(), rand_period(), rand_bytes());
            end else if (r < 40) begin
                pick_pair(h, o);
                issue(KIND_CLOSE, h, o, rand_period(), rand_bytes());
            end else if (r < 65) begin
                pick_pair(h, o);
                issue(KIND_SET, h, o, rand_period(), rand_bytes());
            end else begin
                issue(KIND_TICK, rand_id(), rand_id(), rand_period(), rand_bytes());
            end
            pause(n >= 20 && n < 50);
        end

        // drain: close every pair still known
        while (pair_pool.size() != 0) begin
            p = pair_pool.pop_front();
            issue(KIND_CLOSE, p.h, p.o, rand_period(), rand_bytes());
            pause(1'b0);
        end
        start <= 1'b0;

        // wait for the last results, then a full sweep for stragglers
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SLOTS_DEF + 8) @(posedge i_clk);

        $display("requests sent: %0d open, %0d close, %0d set period, %0d tick",
                 issued[int'(KIND_OPEN)], issued[int'(KIND_CLOSE)],
                 issued[int'(KIND_SET)], issued[int'(KIND_TICK)]);
        $display("fire events checked: %0d", fires_seen);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
